FILE: hw/rtl/scds_pkg.sv
// ----------------------------------------------------------------------------
// scds_pkg
// Shared widths, constants and types for the serial clock divider search.
// ----------------------------------------------------------------------------
`default_nettype none

package scds_pkg;

  localparam int DIVIDER_BITS  = 8;
  localparam int PRESCALE_BITS = 3;

  localparam int SRC_W  = 30;
  localparam int TGT_W  = 27;
  localparam int RATE_W = 30;

  localparam int MAX_DIV = (1 << DIVIDER_BITS) - 1;
  localparam int MAX_PRE = (1 << PRESCALE_BITS) - 1;

  localparam int NUM_W = SRC_W;
  localparam int DEN_W = TGT_W + MAX_PRE;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [SRC_W-1:0] SRC_RESET = SRC_W'(24000000);

  localparam logic [DEN_W-1:0] BASE_DEN = DEN_W'((MAX_DIV + 2) << MAX_PRE);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE_ISSUE,
    ST_BASE_WAIT,
    ST_CHECK,
    ST_Q_ISSUE,
    ST_Q_WAIT,
    ST_R_ISSUE,
    ST_R_WAIT
  } scds_state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } scds_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } scds_div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scds_if.sv
// ----------------------------------------------------------------------------
// scds_if
// Valid/ready channels for the target rate beat and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface scds_in_if;
  import scds_pkg::*;

  logic             valid;
  logic             ready;
  logic [TGT_W-1:0] target_rate_hz;

  modport source (output valid, output target_rate_hz, input ready);
  modport sink (input valid, input target_rate_hz, output ready);
endinterface

interface scds_out_if;
  import scds_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [DIVIDER_BITS-1:0]  clock_divider;
  logic [PRESCALE_BITS-1:0] prescale_shift;
  logic [RATE_W-1:0]        achieved_rate_hz;

  modport source (output valid, output clock_divider, output prescale_shift,
                  output achieved_rate_hz, input ready);
  modport sink (input valid, input clock_divider, input prescale_shift,
                input achieved_rate_hz, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/scds_div.sv
// ----------------------------------------------------------------------------
// scds_div
// Shared restoring divider, one quotient bit per cycle, rounds up.
// ----------------------------------------------------------------------------
`default_nettype none

module scds_div
  import scds_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire scds_div_req_t req,
  output scds_div_rsp_t      rsp
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;
  logic             last;

  always_comb begin
    trial   = {rem_r, num_r[NUM_W-1]};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    last    = (cnt_r == CNT_W'(NUM_W - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    if (den_r == '0) begin
      rsp.quot = '0;
    end else begin
      rsp.quot = num_r + NUM_W'(rem_r != '0);
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a run");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/spi_clock_divider_search_top.sv
// Flow: an accepted beat starts a base division for the slowest setting; then,
// while the target is above the best rate, each prescaler tried runs a quotient
// division and a rate division and returns to the check step. One beat at a
// time; the next beat is taken the cycle after the result is loaded. Each
// division issues, produces a 30-bit quotient and hands it back. Reset:
// synchronous, active low; clears the sequencer and output valid and sets src_r to 24000000.
// ----------------------------------------------------------------------------
// spi_clock_divider_search_top
// Searches prescaler and divider for the fastest serial clock not above the
// target (else the slowest setting) with one shared divider, small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_clock_divider_search_top
  import scds_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [SRC_W-1:0] cfg_wdata,
  scds_in_if.sink               in_ch,
  scds_out_if.source            out_ch
);

  scds_state_t state_r;
  scds_state_t state_nxt;

  logic [SRC_W-1:0]         src_r;
  logic [TGT_W-1:0]         target_r;
  logic [PRESCALE_BITS-1:0] pre_r;
  logic [DIVIDER_BITS-1:0]  cand_div_r;
  logic [DIVIDER_BITS-1:0]  best_div_r;
  logic [PRESCALE_BITS-1:0] best_pre_r;
  logic [RATE_W-1:0]        best_rate_r;

  logic                     out_valid_r;
  logic [DIVIDER_BITS-1:0]  out_div_r;
  logic [PRESCALE_BITS-1:0] out_pre_r;
  logic [RATE_W-1:0]        out_rate_r;

  scds_div_req_t div_req;
  scds_div_rsp_t div_rsp;

  logic             in_take;
  logic             out_free;
  logic             keep_going;
  logic             pre_last;
  logic             better;
  logic [DIVIDER_BITS-1:0] clamp_div;

  scds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    in_take    = in_ch.valid && in_ch.ready;
    out_free   = !out_valid_r || out_ch.ready;
    keep_going = ({{(RATE_W - TGT_W){1'b0}}, target_r} > best_rate_r);
    pre_last   = (pre_r == PRESCALE_BITS'(MAX_PRE));
    better     = (div_rsp.quot <= {{(RATE_W - TGT_W){1'b0}}, target_r})
                 && (div_rsp.quot > best_rate_r);
    if (div_rsp.quot < NUM_W'(2)) begin
      clamp_div = '0;
    end else if ((div_rsp.quot - NUM_W'(2)) > NUM_W'(MAX_DIV)) begin
      clamp_div = DIVIDER_BITS'(MAX_DIV);
    end else begin
      clamp_div = DIVIDER_BITS'(div_rsp.quot - NUM_W'(2));
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_BASE_ISSUE;
        end
      end
      ST_BASE_ISSUE: state_nxt = ST_BASE_WAIT;
      ST_BASE_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (keep_going) begin
          state_nxt = ST_Q_ISSUE;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_Q_ISSUE: state_nxt = ST_Q_WAIT;
      ST_Q_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_R_ISSUE;
        end
      end
      ST_R_ISSUE: state_nxt = ST_R_WAIT;
      ST_R_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = src_r;
    div_req.den   = BASE_DEN;
    case (state_r)
      ST_BASE_ISSUE: begin
        div_req.start = 1'b1;
      end
      ST_Q_ISSUE: begin
        div_req.start = 1'b1;
        div_req.den   = DEN_W'(target_r) << pre_r;
      end
      ST_R_ISSUE: begin
        div_req.start = 1'b1;
        div_req.den   = (DEN_W'(cand_div_r) + DEN_W'(2)) << pre_r;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      src_r       <= SRC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        src_r <= cfg_wdata;
      end
      if (state_r == ST_CHECK && !keep_going && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      target_r <= in_ch.target_rate_hz;
    end
    case (state_r)
      ST_BASE_WAIT: begin
        pre_r       <= '0;
        best_div_r  <= DIVIDER_BITS'(MAX_DIV);
        best_pre_r  <= PRESCALE_BITS'(MAX_PRE);
        best_rate_r <= div_rsp.quot;
      end
      ST_Q_WAIT: begin
        if (div_rsp.done) begin
          cand_div_r <= clamp_div;
        end
      end
      ST_R_WAIT: begin
        if (div_rsp.done) begin
          if (better) begin
            best_rate_r <= div_rsp.quot;
            best_div_r  <= cand_div_r;
            best_pre_r  <= pre_r;
          end
          if (pre_last) begin
            // last prescaler: no more candidates
            target_r <= '0;
          end else begin
            pre_r <= pre_r + PRESCALE_BITS'(1);
          end
        end
      end
      ST_CHECK: begin
        if (!keep_going && out_free) begin
          out_div_r  <= best_div_r;
          out_pre_r  <= best_pre_r;
          out_rate_r <= best_rate_r;
        end
      end
      default: begin
        pre_r <= pre_r;
      end
    endcase
  end

  assign in_ch.ready             = (state_r == ST_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.clock_divider    = out_div_r;
  assign out_ch.prescale_shift   = out_pre_r;
  assign out_ch.achieved_rate_hz = out_rate_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == ST_BASE_ISSUE)
    else $error("accepted beat did not start the search");

  a_result_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_CHECK))
    else $error("result loaded outside the check step");

  a_best_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && $past(state_r == ST_R_WAIT))
      |-> best_rate_r >= $past(best_rate_r))
    else $error("best rate went down");
`endif

endmodule

`default_nettype wire
